// File: sv/blkc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the block chain allocator.
// No dependencies; imported by blkc_div, block_chain_allocator and the testbench.
package blkc_pkg;

    localparam int NUM_BLOCKS = 512;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int ENTRY_W    = BLK_W + 1;          // {used, link}
    localparam int EPOCH_W    = 8;

    localparam int OPCODE_W = 2;
    localparam int BYTES_W  = 25;
    localparam int START_W  = 9;
    localparam int BB_W     = 16;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 9;
    localparam int COUNT_W  = 10;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam int DIV_STEPS = BYTES_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOOP      = 2'd3;

    localparam logic [BB_W-1:0] BLOCK_BYTES_RESET = 16'd1024;

    typedef logic [BLK_W-1:0] blk_t;

    typedef struct packed {
        logic               start;
        logic [BYTES_W-1:0] dividend;
        logic [BB_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [BYTES_W-1:0] quotient;
        logic               rem_nz;
    } div_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  first_block;
        logic [COUNT_W-1:0]  block_count;
        logic [FIELD_W-1:0]  link_value;
        logic                block_used;
    } result_t;

endpackage

// File: sv/blkc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module blkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/blkc_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on blkc_pkg.
module blkc_div
    import blkc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BYTES_W-1:0]   quo_reg, quo_next;
    logic [BB_W-1:0]      rem_reg, rem_next;
    logic [BB_W-1:0]      dvs_reg, dvs_next;

    logic [BB_W:0] rem_sh;
    logic [BB_W:0] rem_sub;
    logic          ge;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[BYTES_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[BYTES_W-2:0], ge};
            rem_next = ge ? rem_sub[BB_W-1:0] : rem_sh[BB_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_nz   = rem_reg != '0;

endmodule

// File: sv/block_chain_allocator.sv
`timescale 1ns / 1ps
// Block chain allocator top level: link/used-bit RAM, visit-mark RAM, control sequencer.
// Depends on blkc_pkg, blkc_ram, blkc_div.
// Work per transaction: a lookup reads one RAM entry; a bad start or unused opcode goes straight to the result;
//   free walks the chain one block per cycle (one RAM read each);
//   allocate runs the divider, then scans from block 1 for free blocks, unless none are needed or too few are free.
// One transaction is in work at a time; a finished result waits in the output register.
// Reset (aresetn low, synchronous) starts a clearing pass over both RAMs
//   before s_tready rises; every 255th free with a valid start adds a clearing pass over the mark RAM.
module block_chain_allocator
    import blkc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // byte_count[24:0], start_block[33:25], zero pad
    input  logic [OPCODE_W-1:0]   s_tuser,   // opcode[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // status[1:0], first_block[10:2],
                                             // block_count[20:11], link_value[29:21],
                                             // block_used[30], zero pad

    input  logic                  cfg_wvalid,
    output logic                  cfg_wready,
    input  logic [BB_W-1:0]       cfg_wdata  // block_bytes
);

    // sequencer states
    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DIV      = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_LAST     = 3'd4;
    localparam logic [2:0] S_FREE_CHK = 3'd5;
    localparam logic [2:0] S_LOOKUP   = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [BB_W-1:0]    block_bytes_reg, block_bytes_next;
    blk_t               clr_cnt_reg, clr_cnt_next;
    logic               clr_main_reg, clr_main_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    blk_t               free_cnt_reg, free_cnt_next;
    logic               m_valid_reg, m_valid_next;

    // datapath registers, no reset needed
    blk_t    need_reg, need_next;
    blk_t    cnt_reg, cnt_next;
    blk_t    first_reg, first_next;
    blk_t    prev_reg, prev_next;
    blk_t    scan_reg, scan_next;
    blk_t    addr_q_reg, addr_q_next;     // block whose RAM data arrives this cycle
    result_t res_reg, res_next;
    result_t out_reg, out_next;

    // input fields
    logic [OPCODE_W-1:0] in_op;
    logic [BYTES_W-1:0]  in_bytes;
    logic [START_W-1:0]  in_start;
    logic                s_accept;
    logic                start_in_range;

    // RAM ports
    blk_t               rd_addr;
    logic               main_we;
    blk_t               main_waddr;
    logic [ENTRY_W-1:0] main_wdata;
    logic [ENTRY_W-1:0] main_rdata;
    logic               seen_we;
    blk_t               seen_waddr;
    logic [EPOCH_W-1:0] seen_wdata;
    logic [EPOCH_W-1:0] seen_rdata;
    logic               rd_used;
    blk_t               rd_link;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [BYTES_W-1:0] need_full;

    assign in_op          = s_tuser;
    assign in_bytes       = s_tdata[BYTES_W-1:0];
    assign in_start       = s_tdata[BYTES_W+START_W-1:BYTES_W];
    assign s_tready       = state_reg == S_IDLE;
    assign s_accept       = s_tvalid && s_tready;
    assign cfg_wready     = 1'b1;
    assign start_in_range = int'(in_start) < NUM_BLOCKS;

    assign rd_used   = main_rdata[BLK_W];
    assign rd_link   = main_rdata[BLK_W-1:0];
    assign need_full = div_rsp.quotient + BYTES_W'(div_rsp.rem_nz);

    // block size of zero acts as one
    assign div_req.start    = s_accept && (in_op == OP_ALLOC);
    assign div_req.dividend = in_bytes;
    assign div_req.divisor  = (block_bytes_reg == '0) ? BB_W'(1) : block_bytes_reg;

    blkc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // link table and used bits, one entry per block
    blkc_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BLOCKS)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (rd_addr),
        .rdata (main_rdata)
    );

    // visit marks for loop detection: entry equals epoch when visited by this free
    blkc_ram #(.WIDTH(EPOCH_W), .DEPTH(NUM_BLOCKS)) u_seen_ram (
        .aclk  (aclk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (rd_addr),
        .rdata (seen_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        block_bytes_next = block_bytes_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_main_next    = clr_main_reg;
        epoch_next       = epoch_reg;
        free_cnt_next    = free_cnt_reg;
        m_valid_next     = m_valid_reg;
        need_next        = need_reg;
        cnt_next         = cnt_reg;
        first_next       = first_reg;
        prev_next        = prev_reg;
        scan_next        = scan_reg;
        addr_q_next      = addr_q_reg;
        res_next         = res_reg;
        out_next         = out_reg;

        rd_addr    = '0;
        main_we    = 1'b0;
        main_waddr = addr_q_reg;
        main_wdata = '0;
        seen_we    = 1'b0;
        seen_waddr = addr_q_reg;
        seen_wdata = epoch_reg;

        if (cfg_wvalid && cfg_wready) begin
            block_bytes_next = cfg_wdata;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                main_we    = clr_main_reg;
                main_waddr = clr_cnt_reg;
                main_wdata = '0;
                seen_we    = 1'b1;
                seen_waddr = clr_cnt_reg;
                seen_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == blk_t'(NUM_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                rd_addr = blk_t'(in_start);
                if (s_accept) begin
                    res_next    = '0;
                    cnt_next    = '0;
                    addr_q_next = blk_t'(in_start);
                    case (in_op)
                        OP_ALLOC: begin
                            state_next = S_DIV;
                        end
                        OP_FREE: begin
                            if (in_start == '0 || !start_in_range) begin
                                res_next.status = ST_BAD_START;
                                state_next      = S_RESP;
                            end else begin
                                epoch_next = epoch_reg + 1'b1;
                                state_next = S_FREE_CHK;
                            end
                        end
                        OP_LOOKUP: begin
                            if (!start_in_range) begin
                                res_next.status = ST_BAD_START;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_LOOKUP;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_DIV: begin
                // keep block one in flight so the scan starts with its data
                rd_addr = blk_t'(1);
                if (div_rsp.done) begin
                    res_next    = '0;
                    need_next   = blk_t'(need_full);
                    cnt_next    = '0;
                    addr_q_next = blk_t'(1);
                    scan_next   = blk_t'(2);
                    if (need_full == '0) begin
                        state_next = S_RESP;
                    end else if (need_full > BYTES_W'(free_cnt_reg)) begin
                        res_next.status = ST_NO_SPACE;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                rd_addr     = scan_reg;
                scan_next   = scan_reg + 1'b1;
                addr_q_next = scan_reg;
                if (!rd_used) begin
                    // link the previous free block to this one
                    if (cnt_reg == '0) begin
                        first_next = addr_q_reg;
                    end else begin
                        main_we    = 1'b1;
                        main_waddr = prev_reg;
                        main_wdata = {1'b1, addr_q_reg};
                    end
                    prev_next = addr_q_reg;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == need_reg) begin
                        state_next = S_LAST;
                    end
                end
            end

            S_LAST: begin
                // chain end: used, link zero
                main_we    = 1'b1;
                main_waddr = prev_reg;
                main_wdata = {1'b1, blk_t'(0)};
                res_next.status      = ST_OK;
                res_next.first_block = FIELD_W'(first_reg);
                res_next.block_count = COUNT_W'(cnt_reg);
                free_cnt_next        = free_cnt_reg - cnt_reg;
                state_next           = S_RESP;
            end

            S_FREE_CHK: begin
                rd_addr = rd_link;
                if (seen_rdata == epoch_reg) begin
                    res_next.status      = ST_LOOP;
                    res_next.block_count = COUNT_W'(cnt_reg);
                    state_next           = S_RESP;
                end else begin
                    main_we       = 1'b1;
                    main_wdata    = '0;
                    seen_we       = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    free_cnt_next = free_cnt_reg + blk_t'(rd_used);
                    addr_q_next   = rd_link;
                    if (rd_link == '0) begin
                        res_next.status      = ST_OK;
                        res_next.block_count = COUNT_W'(cnt_reg + 1'b1);
                        state_next           = S_RESP;
                    end else if (rd_link == addr_q_reg) begin
                        // self link: the mark is being written this cycle
                        res_next.status      = ST_LOOP;
                        res_next.block_count = COUNT_W'(cnt_reg + 1'b1);
                        state_next           = S_RESP;
                    end
                end
            end

            S_LOOKUP: begin
                // block zero is reserved and reads as used
                if (addr_q_reg == '0) begin
                    res_next.link_value = '0;
                    res_next.block_used = 1'b1;
                end else begin
                    res_next.link_value = FIELD_W'(rd_link);
                    res_next.block_used = rd_used;
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    if (epoch_reg == '1) begin
                        // marks about to repeat: wipe the mark RAM only
                        epoch_next    = '0;
                        clr_cnt_next  = '0;
                        clr_main_next = 1'b0;
                        state_next    = S_CLEAR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            block_bytes_reg <= BLOCK_BYTES_RESET;
            clr_cnt_reg     <= '0;
            clr_main_reg    <= 1'b1;
            epoch_reg       <= '0;
            free_cnt_reg    <= blk_t'(NUM_BLOCKS - 1);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            block_bytes_reg <= block_bytes_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_main_reg    <= clr_main_next;
            epoch_reg       <= epoch_next;
            free_cnt_reg    <= free_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg   <= need_next;
        cnt_reg    <= cnt_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        scan_reg   <= scan_next;
        addr_q_reg <= addr_q_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.block_used, out_reg.link_value, out_reg.block_count,
                                  out_reg.first_block, out_reg.status});

    // divider is only started when idle
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // free count never exceeds the number of allocatable blocks
    a_free_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(free_cnt_reg) <= NUM_BLOCKS - 1)
        else $error("free block count out of range");

    // scan stops as soon as the requested count is linked
    a_scan_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> cnt_reg < need_reg)
        else $error("allocate scan ran past its block count");

    // a chain walk never runs with the cleared mark value
    a_epoch: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FREE_CHK |-> epoch_reg != '0)
        else $error("chain walk with zero epoch");

    // a lookup in range reads the RAM in the next cycle
    a_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_op == OP_LOOKUP && start_in_range |=> state_reg == S_LOOKUP)
        else $error("lookup did not reach its read cycle");

endmodule

// File: tb/tb_block_chain_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_chain_allocator: directed and random allocate, free and
// lookup transactions checked field by field against an in-bench chain table predictor.
// Depends on blkc_pkg and the block_chain_allocator RTL.
module tb_block_chain_allocator;
    import blkc_pkg::*;

    localparam int HOLD_CYCLES    = 1500;   // long receiver hold-off, fills the block up
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction on any channel
    localparam int TAIL_CYCLES    = 1200;   // beyond a worst-case walk plus a mark-RAM pass
    localparam int NUM_PHASES     = 6;
    localparam int IDLE_PCT       = 32;

    // opcode 3 has no name in the package; the block answers it with an all-zero result
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [NUM_BLOCKS-1:0][BLK_W-1:0] link;
        logic [NUM_BLOCKS-1:0]            used;
    } chain_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [BYTES_W-1:0]  bytes;
        blk_t                blk;
    } chain_cmd_t;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;  // byte_count[24:0], start_block[33:25], zero pad
    logic [OPCODE_W-1:0]  s_tuser    = '0;  // opcode[1:0]
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // status[1:0], first_block[10:2],
                                            // block_count[20:11], link_value[29:21],
                                            // block_used[30], zero pad
    logic                 cfg_wvalid = 1'b0;
    logic                 cfg_wready;
    logic [BB_W-1:0]      cfg_wdata  = '0;  // block_bytes

    // Two copies of the chain table: the plan runs ahead while commands are generated,
    // the model advances only when the block accepts a transaction.
    chain_state_t    plan_state;
    chain_state_t    model_state;
    logic [BB_W-1:0] plan_block_bytes  = BLOCK_BYTES_RESET;
    logic [BB_W-1:0] model_block_bytes = BLOCK_BYTES_RESET;

    chain_cmd_t      pending_cmds[$];
    result_t         expected_results[$];
    blk_t            chain_heads[$];
    logic [BB_W-1:0] cfg_writes[$];

    chain_cmd_t next_cmd;
    result_t    predicted;
    result_t    want_res;

    logic steady      = 1'b0;   // both sides stop idling
    logic hold_armed  = 1'b0;   // set by the sequencer, taken once by the receiver
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;

    int fail_count    = 0;
    int results_seen  = 0;
    int alloc_count   = 0;
    int no_space_count = 0;
    int free_count    = 0;
    int freed_blocks  = 0;
    int lookup_count  = 0;
    int unused_count  = 0;

    int              phase_items[NUM_PHASES]      = '{150, 150, 200, 200, 220, 250};
    logic [BB_W-1:0] phase_block_bytes[NUM_PHASES] =
        '{16'd1024, 16'd0, 16'hFFFF, 16'd1, 16'd512, 16'd0};  // last one drawn at random

    block_chain_allocator u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // One command against a chain table: allocate takes the lowest free blocks in
    // ascending order, free walks and clears a chain, lookup reads one entry.
    task automatic apply_chain_op(inout chain_state_t st, input logic [OPCODE_W-1:0] op,
                                  input logic [BYTES_W-1:0] bytes, input blk_t blk,
                                  input logic [BB_W-1:0] bb, output result_t res);
        int unsigned divisor, need, nfree, taken, prev, b, nb;
        int          i;
        logic [NUM_BLOCKS-1:0] visited;
        logic        walking;
        res = '0;
        case (op)
            OP_ALLOC: begin
                divisor = (bb == '0) ? 1 : 32'(bb);   // size zero behaves as one byte
                need    = bytes / divisor + (((bytes % divisor) != 0) ? 1 : 0);
                nfree   = 0;
                for (i = 1; i < NUM_BLOCKS; i++)
                    if (!st.used[i]) nfree++;
                if (need > nfree) begin
                    res.status = ST_NO_SPACE;      // nothing taken, table untouched
                end else begin
                    taken = 0;
                    prev  = 0;
                    for (i = 1; i < NUM_BLOCKS && taken < need; i++) begin
                        if (!st.used[i]) begin
                            st.used[i] = 1'b1;
                            st.link[i] = '0;
                            if (taken == 0)
                                res.first_block = i[FIELD_W-1:0];
                            else
                                st.link[prev] = i[BLK_W-1:0];
                            prev = i;
                            taken++;
                        end
                    end
                    res.block_count = taken[COUNT_W-1:0];
                end
            end
            OP_FREE: begin
                if (blk == '0 || int'(blk) >= NUM_BLOCKS) begin
                    res.status = ST_BAD_START;
                end else begin
                    visited = '0;
                    taken   = 0;
                    b       = 32'(blk);
                    walking = 1'b1;
                    while (walking && b != 0 && b < NUM_BLOCKS) begin
                        if (visited[b]) begin
                            res.status = ST_LOOP;
                            walking    = 1'b0;
                        end else begin
                            // free blocks on the walk are cleared and counted as well
                            visited[b] = 1'b1;
                            nb         = 32'(st.link[b]);
                            st.link[b] = '0;
                            st.used[b] = 1'b0;
                            taken++;
                            b = nb;
                        end
                    end
                    res.block_count = taken[COUNT_W-1:0];
                end
            end
            OP_LOOKUP: begin
                if (int'(blk) >= NUM_BLOCKS) begin
                    res.status = ST_BAD_START;
                end else begin
                    res.link_value = st.link[blk];
                    res.block_used = st.used[blk];
                end
            end
            default: ;
        endcase
    endtask

    // Queue a command and keep the plan and its list of live chain heads current.
    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [BYTES_W-1:0] bytes,
                             input blk_t blk);
        result_t    res;
        chain_cmd_t cmd;
        int         k;
        apply_chain_op(plan_state, op, bytes, blk, plan_block_bytes, res);
        if (op == OP_ALLOC && res.status == ST_OK && res.block_count != 0)
            chain_heads = {chain_heads, blk_t'(res.first_block)};
        if (op == OP_FREE)
            for (k = chain_heads.size() - 1; k >= 0; k--)
                if (chain_heads[k] == blk) chain_heads.delete(k);
        cmd.op    = op;
        cmd.bytes = bytes;
        cmd.blk   = blk;
        pending_cmds = {pending_cmds, cmd};
    endtask

    // Mostly well-formed traffic: small allocations and frees of live chains, with
    // lookups, plus some noise (random starts, huge lengths, the unused opcode).
    task automatic build_random_cmds(input int count);
        int          made, roll, idx, used_blocks;
        int unsigned need, eff;
        longint unsigned span;
        made = 0;
        while (made < count) begin
            roll        = $urandom_range(99);
            used_blocks = $countones(plan_state.used) - 1;
            eff         = (plan_block_bytes == '0) ? 1 : 32'(plan_block_bytes);
            if (roll < 8) begin
                case ($urandom_range(3))
                    0: queue_cmd(OP_UNUSED, BYTES_W'($urandom), BLK_W'($urandom));
                    1: queue_cmd(OP_FREE, BYTES_W'($urandom), BLK_W'($urandom));
                    2: queue_cmd(OP_ALLOC, BYTES_W'($urandom), BLK_W'($urandom));
                    default: queue_cmd(OP_LOOKUP, BYTES_W'($urandom), BLK_W'($urandom));
                endcase
                if (pending_cmds[$].op != OP_UNUSED) made++;
            end else if (roll < 52 && (used_blocks < 420 || chain_heads.size() == 0)) begin
                need = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6, 1);
                span = longint'(need) * eff;
                if (need != 0 && eff > 1) span = span - $urandom_range(eff - 1);
                if (span > {BYTES_W{1'b1}}) span = {BYTES_W{1'b1}};
                queue_cmd(OP_ALLOC, span[BYTES_W-1:0], BLK_W'($urandom));
                made++;
            end else if (roll < 86 && chain_heads.size() != 0) begin
                idx = $urandom_range(chain_heads.size() - 1);
                queue_cmd(OP_FREE, BYTES_W'($urandom), chain_heads[idx]);
                made++;
            end else begin
                if (chain_heads.size() != 0 && $urandom_range(1) == 1)
                    queue_cmd(OP_LOOKUP, '0,
                              chain_heads[$urandom_range(chain_heads.size() - 1)]);
                else
                    queue_cmd(OP_LOOKUP, '0, BLK_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        fail_count++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    // Input driver: predicts each accepted transaction, then offers the next command
    // unless this cycle is an idle one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_chain_op(model_state, s_tuser, s_tdata[BYTES_W-1:0],
                               s_tdata[BYTES_W +: START_W], model_block_bytes, predicted);
                expected_results = {expected_results, predicted};
                case (s_tuser)
                    OP_ALLOC: begin
                        alloc_count++;
                        if (predicted.status == ST_NO_SPACE) no_space_count++;
                    end
                    OP_FREE: begin
                        free_count++;
                        freed_blocks += int'(predicted.block_count);
                    end
                    OP_LOOKUP: lookup_count++;
                    default:   unused_count++;
                endcase
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    next_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_cmd.op;
                    s_tdata  <= {{(S_TDATA_W - START_W - BYTES_W){1'b0}},
                                 next_cmd.blk, next_cmd.bytes};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver: checks against the oldest prediction, drives m_tready
    // with random stalls and the one long hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result with nothing expected: tdata %h", m_tdata);
                end else begin
                    want_res = expected_results.pop_front();
                    if (m_tdata[1:0] !== want_res.status)
                        report_mismatch("status", want_res.status, m_tdata[1:0]);
                    if (m_tdata[10:2] !== want_res.first_block)
                        report_mismatch("first_block", want_res.first_block, m_tdata[10:2]);
                    if (m_tdata[20:11] !== want_res.block_count)
                        report_mismatch("block_count", want_res.block_count, m_tdata[20:11]);
                    if (m_tdata[29:21] !== want_res.link_value)
                        report_mismatch("link_value", want_res.link_value, m_tdata[29:21]);
                    if (m_tdata[30] !== want_res.block_used)
                        report_mismatch("block_used", want_res.block_used, m_tdata[30]);
                end
            end
            if (hold_armed && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Configuration channel: one block_bytes write per queued value.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wvalid && cfg_wready)
                model_block_bytes <= cfg_wdata;
            if (!cfg_wvalid || cfg_wready) begin
                if (cfg_writes.size() != 0) begin
                    cfg_wvalid <= 1'b1;
                    cfg_wdata  <= cfg_writes.pop_front();
                end else begin
                    cfg_wvalid <= 1'b0;
                end
            end
        end
    end

    // Watchdog: the reset clearing pass, the long hold and the slowest walk all fit well
    // inside the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_wvalid && cfg_wready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequencer: reset, then one phase per block size; the table is written only while
    // the block is idle and every expected result has come back.
    initial begin
        plan_state          = '0;
        plan_state.used[0]  = 1'b1;     // block zero is reserved
        model_state         = plan_state;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset block size of 1024 bytes.
        queue_cmd(OP_LOOKUP, '0, 9'd0);            // reserved block reads used, link 0
        queue_cmd(OP_LOOKUP, '0, 9'd511);
        queue_cmd(OP_FREE,   '0, 9'd0);            // bad start
        queue_cmd(OP_UNUSED, {BYTES_W{1'b1}}, 9'd511);
        queue_cmd(OP_ALLOC,  '0, '0);              // zero length takes nothing
        queue_cmd(OP_ALLOC,  25'd1, '0);           // block 1
        queue_cmd(OP_ALLOC,  25'd1024, '0);        // exact fit, block 2
        queue_cmd(OP_ALLOC,  25'd1025, '0);        // rounds up, blocks 3 and 4
        queue_cmd(OP_ALLOC,  {BYTES_W{1'b1}}, '0); // no space
        queue_cmd(OP_LOOKUP, '0, 9'd3);
        queue_cmd(OP_LOOKUP, '0, 9'd4);
        queue_cmd(OP_FREE,   '0, 9'd3);
        queue_cmd(OP_FREE,   '0, 9'd511);          // walk over a block that was free
        queue_cmd(OP_FREE,   '0, 9'd1);
        queue_cmd(OP_FREE,   '0, 9'd2);
        queue_cmd(OP_ALLOC,  25'd523264, '0);      // every block, 1 to 511
        queue_cmd(OP_ALLOC,  25'd1, '0);           // full table
        queue_cmd(OP_LOOKUP, '0, 9'd511);
        queue_cmd(OP_LOOKUP, '0, 9'd256);
        queue_cmd(OP_FREE,   '0, 9'd1);            // longest chain
        queue_cmd(OP_ALLOC,  25'd2047, '0);
        queue_cmd(OP_FREE,   '0, 9'd200);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                plan_block_bytes = (phase == NUM_PHASES - 1) ?
                                   BB_W'($urandom_range(16'hFFFF, 2)) : phase_block_bytes[phase];
                cfg_writes = {cfg_writes, plan_block_bytes};
                @(negedge aclk);
                while (cfg_writes.size() != 0 || cfg_wvalid) @(negedge aclk);
            end
            steady = (phase == 2);
            build_random_cmds(phase_items[phase]);
            if (phase == 3) hold_armed = 1'b1;
            // sender pauses here until the block has answered everything
            @(negedge aclk);
            while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(negedge aclk);
            steady = 1'b0;
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $error("%0d expected results never arrived", expected_results.size());
        end

        $display("coverage: %0d allocate (%0d no space), %0d free (%0d blocks), %0d lookup,",
                 alloc_count, no_space_count, free_count, freed_blocks, lookup_count);
        $display("          %0d unused opcode, %0d block sizes, %0d results checked",
                 unused_count, NUM_PHASES, results_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
